// ===== src/sdo_pkg.sv =====
// Package: shared types and constants of the SDO server transfer block
`default_nettype none
package sdo_pkg;

  localparam logic [1:0] FUNC_FRAME = 2'd0;
  localparam logic [1:0] FUNC_LOAD  = 2'd1;
  localparam logic [1:0] FUNC_CLEAR = 2'd2;

  localparam logic [1:0] KIND_FRAME = 2'd0;
  localparam logic [1:0] KIND_DATA  = 2'd1;
  localparam logic [1:0] KIND_STAT  = 2'd2;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_BAD_CMD  = 3'd1;
  localparam logic [2:0] ST_NO_SIZE  = 3'd2;
  localparam logic [2:0] ST_MISMATCH = 3'd3;
  localparam logic [2:0] ST_FULL     = 3'd4;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_DL   = 2'd1;
  localparam logic [1:0] PH_UL   = 2'd2;

  localparam logic [0:0] REG_SERVE_MODE = 1'd0;

  // controller states, one-hot
  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_DEC   = 6'b000010,
    S_DATA  = 6'b000100,
    S_RD    = 6'b001000,
    S_FRAME = 6'b010000,
    S_STAT  = 6'b100000
  } state_e;

  // command from controller to datapath
  typedef struct packed {
    logic capture;   // latch input item
    logic decode;    // evaluate captured item, update session state
    logic rd_issue;  // issue upload store read for byte rd_idx
    logic rd_take;   // store returned read data into frame byte
    logic [2:0] rd_idx;
    logic [2:0] data_idx;
  } cmd_t;

  // plan produced by datapath decode
  typedef struct packed {
    logic [2:0] n_data;   // payload bytes to emit
    logic [2:0] n_rd;     // store bytes to read into the frame
    logic [1:0] rd_base;  // 0: frame byte 4, 1: frame byte 1
    logic       do_frame;
    logic       do_stat;
    logic [2:0] stat;
  } plan_t;

endpackage
`default_nettype wire

// ===== src/sdo_datapath.sv =====
// Datapath: captured item, session registers, upload store and result frame
`default_nettype none
module sdo_datapath #(
  parameter int UPLOAD_DEPTH = 1024
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire sdo_pkg::cmd_t cmd_i,
  output sdo_pkg::plan_t     plan_o,
  input  wire logic          serve_mode_i,
  input  wire logic [1:0]    func_i,
  input  wire logic [7:0]    rx_b0_i, rx_b1_i, rx_b2_i, rx_b3_i,
  input  wire logic [7:0]    rx_b4_i, rx_b5_i, rx_b6_i, rx_b7_i,
  input  wire logic [7:0]    load_byte_i,
  output logic [7:0]         frame_o [8],
  output logic [7:0]         data_o
);
  localparam int AW = (UPLOAD_DEPTH > 1) ? $clog2(UPLOAD_DEPTH) : 1;
  localparam int LW = $clog2(UPLOAD_DEPTH + 1);

  logic [1:0]  func_q;
  logic [7:0]  rx_q [8];
  logic [7:0]  ld_q;
  logic [1:0]  phase_q, phase_d;
  logic [31:0] alen_q, alen_d, cnt_q, cnt_d;
  logic [LW-1:0] ulen_q, ulen_d;
  logic [7:0]  frame_q [8], frame_d [8];
  logic [31:0] base_q, base_d;
  sdo_pkg::plan_t plan_q, plan_d;
  logic [7:0]  mem [UPLOAD_DEPTH];
  logic [7:0]  rdata_q;
  logic [2:0]  rd_pos_q;
  logic        store_we;

  // capture input item
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      func_q <= func_i;
      rx_q[0] <= rx_b0_i; rx_q[1] <= rx_b1_i; rx_q[2] <= rx_b2_i; rx_q[3] <= rx_b3_i;
      rx_q[4] <= rx_b4_i; rx_q[5] <= rx_b5_i; rx_q[6] <= rx_b6_i; rx_q[7] <= rx_b7_i;
      ld_q <= load_byte_i;
    end
  end

  // decode of the captured item
  always_comb begin
    logic [2:0] cs;
    logic [3:0] chunk;
    logic [32:0] sum;
    logic [31:0] rest, ulen32;
    logic [2:0]  uchunk;
    cs = rx_q[0][7:5];
    phase_d = phase_q; alen_d = alen_q; cnt_d = cnt_q; ulen_d = ulen_q;
    base_d = base_q;
    store_we = 1'b0;
    plan_d = '0;
    for (int i = 0; i < 8; i++) frame_d[i] = 8'd0;
    chunk = '0; sum = '0; uchunk = '0;
    ulen32 = 32'(ulen_q);
    rest = (ulen32 > cnt_q) ? ulen32 - cnt_q : 32'd0;
    case (func_q)
      sdo_pkg::FUNC_FRAME: begin
        if (phase_q == sdo_pkg::PH_DL) begin
          if (cs != 3'd0) begin
            phase_d = sdo_pkg::PH_IDLE;
            plan_d.do_stat = 1'b1; plan_d.stat = sdo_pkg::ST_BAD_CMD;
          end else begin
            chunk = 4'd7 - {1'b0, rx_q[0][3:1]};
            plan_d.n_data = chunk[2:0];
            sum = {1'b0, cnt_q} + 33'(chunk);
            cnt_d = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
            frame_d[0] = 8'h20 | (rx_q[0] & 8'h10);
            plan_d.do_frame = 1'b1;
            if (rx_q[0][0] || cnt_d >= alen_q) begin
              phase_d = sdo_pkg::PH_IDLE;
              plan_d.do_stat = 1'b1;
              plan_d.stat = (cnt_d == alen_q) ? sdo_pkg::ST_OK : sdo_pkg::ST_MISMATCH;
            end
          end
        end else if (phase_q == sdo_pkg::PH_UL) begin
          if (cs != 3'd3) begin
            phase_d = sdo_pkg::PH_IDLE;
            plan_d.do_stat = 1'b1; plan_d.stat = sdo_pkg::ST_BAD_CMD;
          end else begin
            uchunk = (rest < 32'd7) ? rest[2:0] : 3'd7;
            plan_d.n_rd = uchunk; plan_d.rd_base = 2'd1;
            base_d = cnt_q;
            cnt_d = cnt_q + 32'(uchunk);
            frame_d[0] = (rx_q[0] & 8'h10) | {4'd0, 3'd7 - uchunk, 1'b0};
            plan_d.do_frame = 1'b1;
            if (32'(uchunk) == rest) begin
              frame_d[0][0] = 1'b1;
              phase_d = sdo_pkg::PH_IDLE;
              plan_d.do_stat = 1'b1;
            end
          end
        end else if (!serve_mode_i) begin
          if (cs != 3'd1) begin
            plan_d.do_stat = 1'b1; plan_d.stat = sdo_pkg::ST_BAD_CMD;
          end else begin
            frame_d[0] = 8'h61;
            frame_d[1] = rx_q[1]; frame_d[2] = rx_q[2]; frame_d[3] = rx_q[3];
            if (rx_q[0][1]) begin
              plan_d.n_data = rx_q[0][0] ? 3'd4 - {1'b0, rx_q[0][3:2]} : 3'd4;
              plan_d.do_frame = 1'b1; plan_d.do_stat = 1'b1;
            end else if (!rx_q[0][0]) begin
              plan_d.do_stat = 1'b1; plan_d.stat = sdo_pkg::ST_NO_SIZE;
            end else begin
              alen_d = {rx_q[7], rx_q[6], rx_q[5], rx_q[4]};
              cnt_d = 32'd0;
              plan_d.do_frame = 1'b1;
              if (alen_d == 32'd0) plan_d.do_stat = 1'b1;
              else phase_d = sdo_pkg::PH_DL;
            end
          end
        end else begin
          if (cs != 3'd2) begin
            plan_d.do_stat = 1'b1; plan_d.stat = sdo_pkg::ST_BAD_CMD;
          end else begin
            frame_d[1] = rx_q[1]; frame_d[2] = rx_q[2]; frame_d[3] = rx_q[3];
            base_d = 32'd0;
            if (ulen32 <= 32'd4) begin
              // n field is 4 - length, so an empty buffer gives 0x53
              frame_d[0] = 8'h43 | {3'd0, 3'd4 - ulen32[2:0], 2'd0};
              plan_d.n_rd = ulen32[2:0]; plan_d.rd_base = 2'd0;
              plan_d.do_frame = 1'b1; plan_d.do_stat = 1'b1;
            end else begin
              frame_d[0] = 8'h41;
              {frame_d[7], frame_d[6], frame_d[5], frame_d[4]} = ulen32;
              cnt_d = 32'd0;
              phase_d = sdo_pkg::PH_UL;
              plan_d.do_frame = 1'b1;
            end
          end
        end
      end
      sdo_pkg::FUNC_LOAD: begin
        if (ulen32 < UPLOAD_DEPTH) begin
          store_we = 1'b1;
          ulen_d = ulen_q + LW'(1);
        end else begin
          plan_d.do_stat = 1'b1; plan_d.stat = sdo_pkg::ST_FULL;
        end
      end
      sdo_pkg::FUNC_CLEAR: begin
        ulen_d = '0; phase_d = sdo_pkg::PH_IDLE; alen_d = '0; cnt_d = '0;
      end
      default: ;
    endcase
  end

  // session registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= sdo_pkg::PH_IDLE;
      alen_q <= '0; cnt_q <= '0; ulen_q <= '0;
    end else if (cmd_i.decode) begin
      phase_q <= phase_d; alen_q <= alen_d; cnt_q <= cnt_d; ulen_q <= ulen_d;
    end
  end

  // plan, frame and read base
  always_ff @(posedge clk_i) begin
    if (cmd_i.decode) begin
      plan_q <= plan_d;
      base_q <= base_d;
      for (int i = 0; i < 8; i++) frame_q[i] <= frame_d[i];
    end else if (cmd_i.rd_take) begin
      frame_q[rd_pos_q] <= rdata_q;
    end
  end

  // upload store: one write, one registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.decode && store_we) mem[ulen_q[AW-1:0]] <= ld_q;
    if (cmd_i.rd_issue) begin
      rdata_q  <= mem[AW'(base_q + 32'(cmd_i.rd_idx))];
      rd_pos_q <= (plan_q.rd_base == 2'd0) ? 3'd4 + cmd_i.rd_idx : 3'd1 + cmd_i.rd_idx;
    end
  end

  function automatic logic [7:0] data_sel(input logic [2:0] idx);
    logic [7:0] v;
    // expedited bytes start at frame byte 4, segment bytes at byte 1
    v = rx_q[3'(idx + (rx_q[0][1] && rx_q[0][7:5] == 3'd1 ? 3'd4 : 3'd1))];
    return v;
  endfunction

  assign plan_o = plan_q;
  assign data_o = data_sel(cmd_i.data_idx);

  always_comb begin
    for (int i = 0; i < 8; i++) frame_o[i] = frame_q[i];
  end
endmodule
`default_nettype wire

// ===== src/sdo_ctrl.sv =====
// Controller: sequences capture, decode, store reads and result items
`default_nettype none
module sdo_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  input  wire logic           out_stall_i,
  output logic [1:0]          kind_o,
  output logic                last_o,
  output sdo_pkg::cmd_t       cmd_o,
  input  wire sdo_pkg::plan_t plan_i
);
  sdo_pkg::state_e state_q, state_d;
  logic [2:0] idx_q, idx_d;
  logic take;

  assign take = out_valid_o && !out_stall_i;
  assign in_stall_o = (state_q != sdo_pkg::S_IDLE);

  // next state
  always_comb begin
    state_d = state_q; idx_d = idx_q;
    cmd_o = '0;
    cmd_o.rd_idx = idx_q; cmd_o.data_idx = idx_q;
    out_valid_o = 1'b0; kind_o = sdo_pkg::KIND_FRAME; last_o = 1'b0;
    unique case (state_q)
      sdo_pkg::S_IDLE: begin
        cmd_o.capture = 1'b1;
        if (in_valid_i) state_d = sdo_pkg::S_DEC;
      end
      sdo_pkg::S_DEC: begin
        cmd_o.decode = 1'b1;
        idx_d = '0;
        state_d = sdo_pkg::S_DATA;
      end
      sdo_pkg::S_DATA: begin
        if (idx_q < plan_i.n_data) begin
          out_valid_o = 1'b1; kind_o = sdo_pkg::KIND_DATA;
          last_o = (idx_q + 3'd1 == plan_i.n_data) && !plan_i.do_frame && !plan_i.do_stat;
          if (take) idx_d = idx_q + 3'd1;
        end else begin
          idx_d = '0;
          state_d = sdo_pkg::S_RD;
        end
      end
      sdo_pkg::S_RD: begin
        // one read issued per cycle; its data is written into the frame in the cycle after
        if (idx_q < plan_i.n_rd) begin
          cmd_o.rd_issue = 1'b1;
          idx_d = idx_q + 3'd1;
        end else begin
          state_d = sdo_pkg::S_FRAME;
        end
        cmd_o.rd_take = (idx_q != 3'd0);
      end
      sdo_pkg::S_FRAME: begin
        if (plan_i.do_frame) begin
          out_valid_o = 1'b1;
          last_o = !plan_i.do_stat;
          if (take) state_d = plan_i.do_stat ? sdo_pkg::S_STAT : sdo_pkg::S_IDLE;
        end else begin
          state_d = plan_i.do_stat ? sdo_pkg::S_STAT : sdo_pkg::S_IDLE;
        end
      end
      sdo_pkg::S_STAT: begin
        out_valid_o = 1'b1; kind_o = sdo_pkg::KIND_STAT; last_o = 1'b1;
        if (take) state_d = sdo_pkg::S_IDLE;
      end
      default: state_d = sdo_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sdo_pkg::S_IDLE;
      idx_q <= '0;
    end else begin
      state_q <= state_d;
      idx_q <= idx_d;
    end
  end
endmodule
`default_nettype wire

// ===== src/sdo_server_transfer.sv =====
// Top level: SDO server transfer, controller plus datapath and config register
//
//  channel  | handshake             | payload
//  ---------+-----------------------+-------------------------------------
//  in       | in_valid_i/in_stall_o | func, rx_b0..rx_b7, load_byte
//  out      | out_valid_o/out_stall_i | out_kind, tx_b0..7, data_byte, status, last
//  config   | APB psel/penable      | serve_mode at address 0
//
// One item at a time: taken in the idle state, then decoded, then its payload
// bytes are emitted, then the upload store is read (single read port), then a
// frame slot and an optional status item follow. Reset clears session state and
// length; the upload store is not cleared.
// An output stall holds the current result item; input is stalled meanwhile.
`default_nettype none
module sdo_server_transfer #(
  parameter int UPLOAD_DEPTH = 1024
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [1:0] func_i,
  input  wire logic [7:0] rx_b0_i, rx_b1_i, rx_b2_i, rx_b3_i,
  input  wire logic [7:0] rx_b4_i, rx_b5_i, rx_b6_i, rx_b7_i,
  input  wire logic [7:0] load_byte_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [1:0]      out_kind_o,
  output logic [7:0]      tx_b0_o, tx_b1_o, tx_b2_o, tx_b3_o,
  output logic [7:0]      tx_b4_o, tx_b5_o, tx_b6_o, tx_b7_o,
  output logic [7:0]      data_byte_o,
  output logic [2:0]      status_o,
  output logic            last_o,
  input  wire logic       psel,
  input  wire logic       penable,
  input  wire logic       pwrite,
  input  wire logic [0:0] paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]     prdata,
  output logic            pready
);
  sdo_pkg::cmd_t  cmd;
  sdo_pkg::plan_t plan;
  logic [7:0] frame [8];
  logic [7:0] dbyte;
  logic [1:0] kind;
  logic serve_mode_q;

  // config register
  assign pready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) serve_mode_q <= 1'b0;
    else if (psel && penable && pwrite && paddr == sdo_pkg::REG_SERVE_MODE)
      serve_mode_q <= pwdata[0];
  end
  assign prdata = (paddr == sdo_pkg::REG_SERVE_MODE) ? {31'd0, serve_mode_q} : 32'd0;

  sdo_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
    .kind_o(kind), .last_o, .cmd_o(cmd), .plan_i(plan)
  );

  sdo_datapath #(.UPLOAD_DEPTH(UPLOAD_DEPTH)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .plan_o(plan), .serve_mode_i(serve_mode_q),
    .func_i, .rx_b0_i, .rx_b1_i, .rx_b2_i, .rx_b3_i, .rx_b4_i, .rx_b5_i,
    .rx_b6_i, .rx_b7_i, .load_byte_i, .frame_o(frame), .data_o(dbyte)
  );

  // result fields, zero outside their kind
  always_comb begin
    logic f;
    f = (kind == sdo_pkg::KIND_FRAME);
    out_kind_o = kind;
    tx_b0_o = f ? frame[0] : 8'd0; tx_b1_o = f ? frame[1] : 8'd0;
    tx_b2_o = f ? frame[2] : 8'd0; tx_b3_o = f ? frame[3] : 8'd0;
    tx_b4_o = f ? frame[4] : 8'd0; tx_b5_o = f ? frame[5] : 8'd0;
    tx_b6_o = f ? frame[6] : 8'd0; tx_b7_o = f ? frame[7] : 8'd0;
    data_byte_o = (kind == sdo_pkg::KIND_DATA) ? dbyte : 8'd0;
    status_o = (kind == sdo_pkg::KIND_STAT) ? plan.stat : 3'd0;
  end
endmodule
`default_nettype wire

// ===== tb/sv/sdo_checker.sv =====
// Checker: watches both channels of the SDO server, predicts results and compares them
`timescale 1ns / 100ps
`default_nettype none
module sdo_checker
  import sdo_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  input  wire logic       in_stall_i,
  input  wire logic [1:0] func_i,
  input  wire logic [7:0] rx_b0_i, rx_b1_i, rx_b2_i, rx_b3_i,
  input  wire logic [7:0] rx_b4_i, rx_b5_i, rx_b6_i, rx_b7_i,
  input  wire logic [7:0] load_byte_i,
  input  wire logic       out_valid_i,
  input  wire logic       out_stall_i,
  input  wire logic [1:0] out_kind_i,
  input  wire logic [7:0] tx_b0_i, tx_b1_i, tx_b2_i, tx_b3_i,
  input  wire logic [7:0] tx_b4_i, tx_b5_i, tx_b6_i, tx_b7_i,
  input  wire logic [7:0] data_byte_i,
  input  wire logic [2:0] status_i,
  input  wire logic       last_i,
  input  wire logic       cfg_we_i,
  input  wire logic       serve_mode_i,
  output int              fail_count_o,
  output int              pending_o,
  output int              results_seen_o
);
  localparam int DEPTH = 1024;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0][7:0] frame;  // frame[i] is byte i
    logic [7:0] data;
    logic [2:0] status;
    logic last;
  } reply_t;

  reply_t     replies_due[$];
  logic       mode_q;
  logic [1:0] phase_q;
  logic [31:0] size_q;
  logic [31:0] moved_q;
  logic [7:0] ubuf[DEPTH];
  int         ulen_q;
  int         n_new;

  assign pending_o = replies_due.size();

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %0h, want %0h at %0t", what, got, want, $realtime);
    fail_count_o++;
  endtask

  function automatic reply_t mk(input logic [1:0] kind, input logic [7:0][7:0] fr,
                                input logic [7:0] d, input logic [2:0] st);
    reply_t r;
    r.kind = kind;
    r.frame = (kind == KIND_FRAME) ? fr : '0;
    r.data = d;
    r.status = st;
    r.last = 1'b0;
    return r;
  endfunction

  task automatic push(input reply_t r);
    replies_due.push_back(r);
    n_new++;
  endtask

  // work out the replies for one accepted item
  task automatic predict_item(input logic [1:0] fn, input logic [7:0][7:0] rx,
                              input logic [7:0] lb);
    logic [7:0][7:0] fr;
    int len, chunk, rest;
    logic [32:0] sum;
    logic fin;
    n_new = 0;
    fr = '0;
    if (fn == FUNC_FRAME) begin
      if (phase_q == PH_DL) begin
        // download segment
        if (rx[0][7:5] != 3'd0) begin
          phase_q = PH_IDLE;
          push(mk(KIND_STAT, fr, 8'd0, ST_BAD_CMD));
        end else begin
          chunk = 7 - rx[0][3:1];
          for (int i = 0; i < chunk; i++) push(mk(KIND_DATA, fr, rx[1+i], ST_OK));
          sum = {1'b0, moved_q} + chunk;
          moved_q = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
          fr[0] = 8'h20 | (rx[0] & 8'h10);
          push(mk(KIND_FRAME, fr, 8'd0, ST_OK));
          if (rx[0][0] || moved_q >= size_q) begin
            phase_q = PH_IDLE;
            push(mk(KIND_STAT, '0, 8'd0, (moved_q == size_q) ? ST_OK : ST_MISMATCH));
          end
        end
      end else if (phase_q == PH_UL) begin
        // upload segment
        if (rx[0][7:5] != 3'd3) begin
          phase_q = PH_IDLE;
          push(mk(KIND_STAT, fr, 8'd0, ST_BAD_CMD));
        end else begin
          rest = (ulen_q > moved_q) ? ulen_q - int'(moved_q) : 0;
          chunk = rest < 7 ? rest : 7;
          fin = (chunk == rest);
          fr[0] = (rx[0] & 8'h10) | 8'((7 - chunk) << 1) | {7'd0, fin};
          for (int i = 0; i < chunk; i++) fr[1+i] = ubuf[(int'(moved_q) + i) % DEPTH];
          moved_q = moved_q + chunk;
          push(mk(KIND_FRAME, fr, 8'd0, ST_OK));
          if (fin) begin
            phase_q = PH_IDLE;
            push(mk(KIND_STAT, '0, 8'd0, ST_OK));
          end
        end
      end else if (!mode_q) begin
        // download initiate
        if (rx[0][7:5] != 3'd1) begin
          push(mk(KIND_STAT, fr, 8'd0, ST_BAD_CMD));
        end else begin
          fr[0] = 8'h61; fr[1] = rx[1]; fr[2] = rx[2]; fr[3] = rx[3];
          if (rx[0][1]) begin
            len = rx[0][0] ? 4 - rx[0][3:2] : 4;
            for (int i = 0; i < len; i++) push(mk(KIND_DATA, '0, rx[4+i], ST_OK));
            push(mk(KIND_FRAME, fr, 8'd0, ST_OK));
            push(mk(KIND_STAT, '0, 8'd0, ST_OK));
          end else if (!rx[0][0]) begin
            push(mk(KIND_STAT, '0, 8'd0, ST_NO_SIZE));
          end else begin
            size_q = {rx[7], rx[6], rx[5], rx[4]};
            moved_q = '0;
            push(mk(KIND_FRAME, fr, 8'd0, ST_OK));
            if (size_q == 0) push(mk(KIND_STAT, '0, 8'd0, ST_OK));
            else phase_q = PH_DL;
          end
        end
      end else begin
        // upload initiate
        if (rx[0][7:5] != 3'd2) begin
          push(mk(KIND_STAT, fr, 8'd0, ST_BAD_CMD));
        end else begin
          fr[1] = rx[1]; fr[2] = rx[2]; fr[3] = rx[3];
          if (ulen_q <= 4) begin
            fr[0] = 8'h43 | 8'((4 - ulen_q) << 2);
            for (int i = 0; i < ulen_q; i++) fr[4+i] = ubuf[i];
            push(mk(KIND_FRAME, fr, 8'd0, ST_OK));
            push(mk(KIND_STAT, '0, 8'd0, ST_OK));
          end else begin
            fr[0] = 8'h41;
            {fr[7], fr[6], fr[5], fr[4]} = ulen_q;
            moved_q = '0;
            phase_q = PH_UL;
            push(mk(KIND_FRAME, fr, 8'd0, ST_OK));
          end
        end
      end
    end else if (fn == FUNC_LOAD) begin
      if (ulen_q < DEPTH) begin
        ubuf[ulen_q] = lb;
        ulen_q++;
      end else begin
        push(mk(KIND_STAT, '0, 8'd0, ST_FULL));
      end
    end else if (fn == FUNC_CLEAR) begin
      ulen_q = 0;
      phase_q = PH_IDLE;
      size_q = '0;
      moved_q = '0;
    end
    if (n_new > 0) replies_due[$].last = 1'b1;
  endtask

  // compare one accepted result with the oldest prediction
  task automatic check_reply(input reply_t got);
    reply_t want;
    if (replies_due.size() == 0) begin
      report("unexpected result kind", got.kind, '0);
      return;
    end
    want = replies_due.pop_front();
    if (got.kind != want.kind) report("out_kind", got.kind, want.kind);
    for (int i = 0; i < 8; i++)
      if (got.frame[i] != want.frame[i])
        report($sformatf("tx_b%0d", i), got.frame[i], want.frame[i]);
    if (got.data != want.data) report("data_byte", got.data, want.data);
    if (got.status != want.status) report("status", got.status, want.status);
    if (got.last != want.last) report("last", got.last, want.last);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    reply_t got;
    if (!rst_ni) begin
      mode_q <= 1'b0;
      phase_q = PH_IDLE;
      size_q = '0;
      moved_q = '0;
      ulen_q = 0;
      fail_count_o = 0;
      results_seen_o = 0;
      replies_due.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        got.kind = out_kind_i;
        got.frame = {tx_b7_i, tx_b6_i, tx_b5_i, tx_b4_i, tx_b3_i, tx_b2_i, tx_b1_i, tx_b0_i};
        got.data = data_byte_i;
        got.status = status_i;
        got.last = last_i;
        check_reply(got);
        results_seen_o++;
      end
      if (in_valid_i && !in_stall_i)
        predict_item(func_i, {rx_b7_i, rx_b6_i, rx_b5_i, rx_b4_i,
                              rx_b3_i, rx_b2_i, rx_b1_i, rx_b0_i}, load_byte_i);
      if (cfg_we_i) mode_q <= serve_mode_i;
    end
  end
endmodule
`default_nettype wire

// ===== tb/sv/tb.sv =====
// Testbench top: stimulus, idling and verdict for the SDO server transfer block
`timescale 1ns / 100ps
`default_nettype none
module tb;
  import sdo_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [1:0] func_i = FUNC_CLEAR;
  logic [7:0][7:0] rx = '0;
  logic [7:0] load_byte_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [1:0] out_kind_o;
  logic [7:0] tx_b0_o, tx_b1_o, tx_b2_o, tx_b3_o, tx_b4_o, tx_b5_o, tx_b6_o, tx_b7_o;
  logic [7:0] data_byte_o;
  logic [2:0] status_o;
  logic last_o;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [0:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  int fail_count, pending, results_seen;
  int hold_off = 0;       // receiver long hold-off in cycles
  int item_count = 0;
  bit timed_out = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  sdo_server_transfer DUT (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .func_i,
    .rx_b0_i(rx[0]), .rx_b1_i(rx[1]), .rx_b2_i(rx[2]), .rx_b3_i(rx[3]),
    .rx_b4_i(rx[4]), .rx_b5_i(rx[5]), .rx_b6_i(rx[6]), .rx_b7_i(rx[7]),
    .load_byte_i, .out_valid_o, .out_stall_i, .out_kind_o,
    .tx_b0_o, .tx_b1_o, .tx_b2_o, .tx_b3_o, .tx_b4_o, .tx_b5_o, .tx_b6_o, .tx_b7_o,
    .data_byte_o, .status_o, .last_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  sdo_checker u_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .func_i,
    .rx_b0_i(rx[0]), .rx_b1_i(rx[1]), .rx_b2_i(rx[2]), .rx_b3_i(rx[3]),
    .rx_b4_i(rx[4]), .rx_b5_i(rx[5]), .rx_b6_i(rx[6]), .rx_b7_i(rx[7]),
    .load_byte_i, .out_valid_i(out_valid_o), .out_stall_i, .out_kind_i(out_kind_o),
    .tx_b0_i(tx_b0_o), .tx_b1_i(tx_b1_o), .tx_b2_i(tx_b2_o), .tx_b3_i(tx_b3_o),
    .tx_b4_i(tx_b4_o), .tx_b5_i(tx_b5_o), .tx_b6_i(tx_b6_o), .tx_b7_i(tx_b7_o),
    .data_byte_i(data_byte_o), .status_i(status_o), .last_i(last_o),
    .cfg_we_i(psel && penable && pwrite && pready && paddr == REG_SERVE_MODE),
    .serve_mode_i(pwdata[0]),
    .fail_count_o(fail_count), .pending_o(pending), .results_seen_o(results_seen)
  );

  // receiver: random stall pattern, plus a long hold-off when requested
  always @(posedge clk_i) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= (($urandom_range(0, 7) < 2) && ((item_count / 40) % 3 != 1));
    end
  end

  // offer one item and wait for acceptance
  task automatic send(input logic [1:0] fn, input logic [7:0][7:0] frame,
                      input logic [7:0] lb);
    func_i <= fn;
    rx <= frame;
    load_byte_i <= lb;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    item_count++;
  endtask

  // gap after an item: bursts with random gaps
  task automatic gap();
    if ((item_count / 40) % 3 != 1 && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  task automatic frame_item(input logic [7:0][7:0] frame);
    send(FUNC_FRAME, frame, 8'($urandom));
    gap();
  endtask

  task automatic load_item(input logic [7:0] b);
    logic [7:0][7:0] noise;
    noise = {$urandom, $urandom};
    send(FUNC_LOAD, noise, b);
    gap();
  endtask

  task automatic clear_item();
    send(FUNC_CLEAR, {$urandom, $urandom}, 8'($urandom));
    gap();
  endtask

  // wait until the block is idle, then let its pipeline drain
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic set_mode(input logic m);
    drain();
    psel <= 1'b1; pwrite <= 1'b1; paddr <= REG_SERVE_MODE; pwdata <= {31'($urandom), m};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [7:0][7:0] rnd_frame(input logic [7:0] b0);
    logic [7:0][7:0] f;
    f = {$urandom, $urandom};
    f[0] = b0;
    return f;
  endfunction

  // segmented download with random content, optionally ended early or with a wrong announced size
  task automatic seg_download(input int total, input bit early_end, input bit bad_len);
    int left, c;
    logic [7:0][7:0] f;
    logic tog;
    f = rnd_frame({3'd1, 1'b0, 2'($urandom), 1'b0, 1'b1});
    {f[7], f[6], f[5], f[4]} = bad_len ? total + 3 : total;
    frame_item(f);
    left = total;
    tog = 1'b0;
    while (left > 0) begin
      c = (left < 7) ? left : 7;
      if (early_end || $urandom_range(0, 3) == 0) c = $urandom_range(0, c);
      left -= c;
      f = rnd_frame({3'd0, tog, 3'(7 - c), (left == 0 || (early_end && left < 5))});
      frame_item(f);
      if (f[0][0] || (left == 0 && !bad_len)) break;
      tog = ~tog;
      if (left == 0) left = 1;
    end
  endtask

  task automatic seg_upload(input int nbytes);
    logic tog;
    clear_item();
    for (int i = 0; i < nbytes; i++) load_item(8'($urandom));
    frame_item(rnd_frame({3'd2, 5'($urandom)}));
    tog = 1'b0;
    if (nbytes > 4)
      for (int i = 0; i < (nbytes + 6) / 7; i++) begin
        frame_item(rnd_frame({3'd3, tog, 4'($urandom)}));
        tog = ~tog;
      end
  endtask

  initial begin
    #200000000;
    timed_out = 1'b1;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    logic [7:0][7:0] f;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: expedited downloads of every size, with and without size bit
    for (int n = 0; n < 4; n++) frame_item(rnd_frame({3'd1, 1'b0, 2'(n), 2'b11}));
    frame_item({8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h22});
    frame_item({8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h2E});
    frame_item(rnd_frame(8'h20));                   // no size
    frame_item(rnd_frame(8'hE0));                   // bad command
    frame_item({32'd0, 24'h123456, 8'h21});         // zero announced size
    seg_download(10, 1'b0, 1'b0);
    seg_download(9, 1'b1, 1'b0);                    // mismatch by early last
    f = rnd_frame(8'h21);
    {f[7], f[6], f[5], f[4]} = 32'hFFFF_FFFF;
    frame_item(f);
    frame_item(rnd_frame(8'h00));
    frame_item(rnd_frame(8'h80));                   // bad command inside a session
    send(2'd3, rnd_frame(8'h21), 8'h00);            // unused code
    // directed uploads: zero length, short, segmented
    set_mode(1'b1);
    clear_item();
    frame_item(rnd_frame(8'h40));
    seg_upload(3);
    seg_upload(12);
    frame_item(rnd_frame(8'h40));
    frame_item(rnd_frame(8'h60));
    frame_item(rnd_frame(8'hFF));                   // bad segment command
    frame_item(rnd_frame(8'h40));
    load_item(8'hA5);                               // load during session
    frame_item(rnd_frame(8'h70));
    drain();
    item_count = 0;

    // random part
    for (int ph = 0; ph < 8; ph++) begin
      set_mode(ph[0]);
      if (ph == 3) begin
        // long receiver hold-off while items keep coming
        hold_off <= 300;
        @(posedge clk_i);
      end
      for (int j = 0; j < 8; j++) begin
        case ($urandom_range(0, 5))
          0: frame_item(rnd_frame(8'($urandom)));
          1: clear_item();
          2: load_item(8'($urandom));
          default: begin
            if (!ph[0]) begin
              if ($urandom_range(0, 1))
                frame_item(rnd_frame({3'd1, 3'($urandom), 1'b1, 1'($urandom)}));
              else seg_download($urandom_range(1, 30), $urandom_range(0, 3) == 0,
                                $urandom_range(0, 4) == 0);
            end else begin
              seg_upload($urandom_range(0, 20));
            end
          end
        endcase
      end
    end
    drain();

    $display("covered %0d random items and %0d results in both serve modes,",
             item_count, results_seen);
    $display("including expedited, segmented, error and clear cases");
    if (fail_count == 0 && !timed_out) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
`default_nettype wire
